// ----- hdl/dss_pkg.sv -----
// Shared types and constants for the drum step sequencer.
package dss_pkg;

  typedef enum logic [3:0] {
    CMD_TICK    = 4'd0,
    CMD_NOTE_ON = 4'd1,
    CMD_NOTE_OFF = 4'd2,
    CMD_MUTE    = 4'd3,
    CMD_UNMUTE  = 4'd4,
    CMD_LONGER  = 4'd5,
    CMD_SHORTER = 4'd6,
    CMD_FASTER  = 4'd7,
    CMD_SLOWER  = 4'd8
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } seq_state_t;

  // Grid size; the command and result port widths are fixed to match it.
  localparam int NUM_STEPS    = 32;
  localparam int NUM_CHANNELS = 8;

  localparam int DELAY_W = 8;
  localparam logic [DELAY_W-1:0] DELAY_RESET  = 8'd100;
  localparam logic [DELAY_W-1:0] DELAY_FAST_MIN = 8'd10;
  localparam logic [DELAY_W-1:0] DELAY_FAST_DEC = 8'd5;
  localparam logic [DELAY_W-1:0] DELAY_SLOW_MAX = 8'd200;
  localparam logic [DELAY_W-1:0] DELAY_SLOW_INC = 8'd10;
  localparam int LOOP_RESET = 15;
  localparam int LOOP_MIN   = 2;

endpackage

// ----- hdl/dss_grid.sv -----
// Note grid memory with one registered read port, one write port and per-column valid bits.
module dss_grid #(
  parameter int STEPS    = 32,
  parameter int CHANNELS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [$clog2(STEPS)-1:0]   rd_addr,
  output logic [CHANNELS-1:0]        rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(STEPS)-1:0]   wr_addr,
  input  logic [CHANNELS-1:0]        wr_data
);
  import dss_pkg::*;

  localparam int AW = $clog2(STEPS);

  logic [CHANNELS-1:0] mem [STEPS];
  logic [STEPS-1:0]    col_valid;
  logic [CHANNELS-1:0] rd_q;
  logic                rd_hit;
  logic                rd_ok;
  logic                wr_ok;

  assign rd_ok = {1'b0, rd_addr} < (AW+1)'(STEPS);
  assign wr_ok = {1'b0, wr_addr} < (AW+1)'(STEPS);

  // A column that was never written since reset reads as all zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_valid <= '0;
    end else if (wr_en && wr_ok) begin
      col_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_hit <= rd_ok && col_valid[rd_addr];
      if (rd_ok) begin
        rd_q <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_hit ? rd_q : '0;

endmodule

// ----- hdl/drum_step_sequencer.sv -----
// Top level of the drum step sequencer: command decode, play state and result register.
// A command beat is captured on acceptance; its result beat is registered when the
// execute state completes. The grid read at acceptance and the read-modify-write in
// execute bar a new command until the last is done; a stalled result holds the block.
// Reset (rst, synchronous, active high) clears all note columns through their valid
// bits at once, unmutes every channel, sets position 0, loop end 15 and delay 100.
// No clearing pass is needed, so a command is accepted in the cycle after reset.
module drum_step_sequencer (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [3:0] command,
  input  logic [2:0] channel,
  input  logic [4:0] step,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] triggers,
  output logic [4:0] position,
  output logic [7:0] tick_delay,
  output logic [4:0] loop_end
);
  import dss_pkg::*;

  // The grid size is fixed by the package, since the port widths depend on it.
  localparam int STEPS    = NUM_STEPS;
  localparam int CHANNELS = NUM_CHANNELS;

  // Position and loop end get at least five bits, the width of their ports, so the loop
  // end can reset to 15 even for a short grid.
  localparam int AW = $clog2(STEPS);
  localparam int LW = (AW > 5) ? AW : 5;

  seq_state_t state, state_next;

  // The command beat is captured at acceptance and used in the execute state.
  logic [3:0] cmd_q;
  logic [2:0] chan_q;
  logic [4:0] step_q;

  // Play state.
  logic [CHANNELS-1:0] mute;
  logic [CHANNELS-1:0] mute_next;
  logic [LW-1:0]       pos;
  logic [LW-1:0]       pos_next;
  logic [LW-1:0]       loop_q;
  logic [LW-1:0]       loop_next;
  logic [DELAY_W-1:0]  delay;
  logic [DELAY_W-1:0]  delay_next;
  logic [7:0]          trig;
  logic [7:0]          trig_next;

  // Control.
  logic accept;
  logic exec_go;

  // Grid port signals.
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [CHANNELS-1:0] rd_col;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [CHANNELS-1:0] wr_col;

  // Decoded helpers.
  logic [LW-1:0]       tick_pos;
  logic                tick_in_grid;
  logic [CHANNELS-1:0] chan_sel;
  logic                chan_ok;
  logic                step_ok;
  logic                in_chan_ok;

  // The position a tick moves to; the state does not change between acceptance
  // and execution, so the same value addresses the read and updates the position.
  assign tick_pos     = (pos >= loop_q) ? '0 : pos + LW'(1);
  assign tick_in_grid = {1'b0, tick_pos} < (LW+1)'(STEPS);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs and sequencing strobes.
  always_comb begin
    cmd_stall = 1'b1;
    exec_go   = 1'b0;
    case (state)
      ST_IDLE: begin
        // No command is taken while reset is held.
        cmd_stall = rst;
      end
      ST_EXEC: begin
        exec_go = !res_valid || !res_stall;
      end
      default: begin
        cmd_stall = 1'b1;
      end
    endcase
  end

  assign accept = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= command;
      chan_q <= channel;
      step_q <= step;
    end
  end

  // The grid is read in the accept cycle: the new column for a tick, the addressed
  // column for a note command. Other commands read harmlessly.
  assign in_chan_ok = 1'b1;
  assign rd_en   = accept && in_chan_ok;
  assign rd_addr = (cmd_t'(command) == CMD_TICK) ? AW'(tick_pos) : AW'(step);

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      chan_sel[c] = (32'(chan_q) == 32'(c));
    end
  end

  assign chan_ok = 32'(chan_q) < 32'(CHANNELS);
  assign step_ok = 32'(step_q) < 32'(STEPS);

  // Execute: for a note command a read-modify-write of the grid column, plus the register updates.
  always_comb begin
    mute_next  = mute;
    pos_next   = pos;
    loop_next  = loop_q;
    delay_next = delay;
    trig_next  = '0;
    wr_en      = 1'b0;
    wr_col     = rd_col;
    case (cmd_t'(cmd_q))
      CMD_TICK: begin
        pos_next = tick_pos;
        if (tick_in_grid) begin
          trig_next = 8'(rd_col & ~mute);
        end
      end
      CMD_NOTE_ON: begin
        wr_en  = chan_ok && step_ok;
        wr_col = rd_col | chan_sel;
      end
      CMD_NOTE_OFF: begin
        wr_en  = chan_ok && step_ok;
        wr_col = rd_col & ~chan_sel;
      end
      CMD_MUTE: begin
        mute_next = mute | chan_sel;
      end
      CMD_UNMUTE: begin
        mute_next = mute & ~chan_sel;
      end
      CMD_LONGER: begin
        if (loop_q < LW'(STEPS - 1)) begin
          loop_next = loop_q + LW'(1);
        end
      end
      CMD_SHORTER: begin
        if (loop_q > LW'(LOOP_MIN)) begin
          loop_next = loop_q - LW'(1);
        end
      end
      CMD_FASTER: begin
        if (delay >= DELAY_FAST_MIN) begin
          delay_next = delay - DELAY_FAST_DEC;
        end
      end
      CMD_SLOWER: begin
        if (delay <= DELAY_SLOW_MAX) begin
          delay_next = delay + DELAY_SLOW_INC;
        end
      end
      default: begin
        trig_next = '0;
      end
    endcase
  end

  assign wr_addr = AW'(step_q);

  dss_grid #(
    .STEPS    (STEPS),
    .CHANNELS (CHANNELS)
  ) u_grid (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_col),
    .wr_en   (wr_en && exec_go),
    .wr_addr (wr_addr),
    .wr_data (wr_col)
  );

  // Play state only moves when a result beat is loaded, so the status fields seen
  // with a waiting result stay put while it is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      mute  <= '0;
      pos   <= '0;
      loop_q <= LW'(LOOP_RESET);
      delay <= DELAY_RESET;
    end else if (exec_go) begin
      mute  <= mute_next;
      pos   <= pos_next;
      loop_q <= loop_next;
      delay <= delay_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (exec_go) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      trig <= trig_next;
    end
  end

  assign triggers   = trig;
  assign position   = 5'(pos);
  assign tick_delay = delay;
  assign loop_end   = 5'(loop_q);

  // The delay never leaves its floor and ceiling.
  a_delay_range: assert property (@(posedge clk) disable iff (rst)
    (delay >= DELAY_FAST_DEC) && (delay <= DELAY_SLOW_MAX + DELAY_SLOW_INC))
    else $error("tick delay out of range");

  // The loop end never drops below its minimum.
  a_loop_min: assert property (@(posedge clk) disable iff (rst)
    loop_q >= LW'(LOOP_MIN))
    else $error("loop end below minimum");

  // Only a tick fires triggers.
  a_trig_tick_only: assert property (@(posedge clk) disable iff (rst)
    exec_go && (cmd_t'(cmd_q) != CMD_TICK) |=> (triggers == '0))
    else $error("triggers fired by a non-tick command");

  // The position moves only when a tick executes.
  a_pos_on_tick: assert property (@(posedge clk) disable iff (rst)
    !(exec_go && (cmd_t'(cmd_q) == CMD_TICK)) |=> $stable(pos))
    else $error("position changed without a tick");

  // No grid write happens outside the execute state.
  a_write_in_exec: assert property (@(posedge clk) disable iff (rst)
    (wr_en && exec_go) |-> (state == ST_EXEC) && cmd_stall)
    else $error("grid write outside execute");

endmodule
